// ===== design/x86ild_pkg.sv =====
// ----------------------------------------------------------------------------
// x86ild_pkg
// Shared types, constants and the opcode size table of the x86 instruction
// length decoder.
// ----------------------------------------------------------------------------
package x86ild_pkg;

  // Decoder phases within one instruction.
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_OPCODE,
    PH_MODRM,
    PH_GROUP,
    PH_SIB,
    PH_TAIL
  } phase_t;

  // Payload of the code byte channel.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       restart;
  } code_t;

  // Payload of the result channel.
  typedef struct packed {
    logic [5:0] insn_length;
    logic       is_branch;
    logic       bad_code;
  } result_t;

  // Outcome of one table search.
  typedef struct packed {
    logic        found;
    logic        group_wait;
    logic [31:0] entry;
  } match_t;

  // What one decode step hands to the result register.
  typedef struct packed {
    logic       emit;
    logic [5:0] insn_length;
    logic       is_branch;
    logic       bad_code;
  } step_t;

  localparam logic [7:0] BYTE_ESCAPE = 8'h0F;
  localparam logic [7:0] BYTE_OPSIZE = 8'h66;
  localparam logic [7:0] BYTE_ADSIZE = 8'h67;
  localparam logic [7:0] BYTE_SEG_ES = 8'h26;
  localparam logic [7:0] BYTE_SEG_CS = 8'h2E;
  localparam logic [7:0] BYTE_SEG_SS = 8'h36;
  localparam logic [7:0] BYTE_SEG_DS = 8'h3E;
  localparam logic [7:0] BYTE_SEG_FS = 8'h64;
  localparam logic [7:0] BYTE_SEG_GS = 8'h65;
  localparam logic [7:0] BYTE_WAIT   = 8'h9B;
  localparam logic [7:0] BYTE_LOCK   = 8'hF0;
  localparam logic [7:0] BYTE_REPNE  = 8'hF2;
  localparam logic [7:0] BYTE_REP    = 8'hF3;

  // Slots addressable by the table search; slots past the fixed contents
  // read as zero and never match.
  localparam int ROM_SLOTS = 128;
  localparam int ROM_FILL  = 101;

  // Entry layout: 31:24 last opcode, 23:16 first opcode, 15 address-size
  // immediate, 14:12 fixed immediate bytes, 11 operand-size immediate,
  // 10:8 fixed immediate bytes, 6:4 group subcode, 3 branch,
  // 2:1 both set means group entry, 1 ModRM present, 0 escaped opcode.
  localparam logic [31:0] SIZE_ROM [ROM_FILL] = '{
    32'h03000002, 32'h04040100, 32'h05050800, 32'h07060000, 32'h0B080002,
    32'h0C0C0100, 32'h0D0D0800, 32'h0E0E0000, 32'h13100002, 32'h14140100,
    32'h15150800, 32'h17160000, 32'h1B180002, 32'h1C1C0100, 32'h1D1D0800,
    32'h1F1E0000, 32'h23200002, 32'h24240100, 32'h25250800, 32'h27270000,
    32'h2B280002, 32'h2C2C0100, 32'h2D2D0800, 32'h2F2F0000, 32'h33300002,
    32'h34340100, 32'h35350800, 32'h37370000, 32'h3B380002, 32'h3C3C0100,
    32'h3D3D0800, 32'h613F0000, 32'h62620002, 32'h68680800, 32'h69690802,
    32'h6A6A0100, 32'h6B6B0102, 32'h7F700108, 32'h80800102, 32'h81810802,
    32'h83820102, 32'h8E840002, 32'h8F8F0006, 32'h99900000, 32'h9A9A0A08,
    32'h9F9C0000, 32'hA3A08000, 32'hA7A40000, 32'hA9A80100, 32'hAFAA0000,
    32'hB7B00100, 32'hBFB80800, 32'hC1C00102, 32'hC2C20208, 32'hC3C30008,
    32'hC5C40002, 32'hC6C60106, 32'hC7C70806, 32'hC8C80300, 32'hC9C90000,
    32'hCACA0200, 32'hCBCB0000, 32'hCCCC0008, 32'hCDCD0108, 32'hCFCE0008,
    32'hD3D00002, 32'hD5D40100, 32'hD7D60000, 32'hDFD80002, 32'hE3E00108,
    32'hE9E80808, 32'hEAEA0A08, 32'hEBEB0108, 32'hF5F10000, 32'hF6F60106,
    32'hF6F60002, 32'hF7F70806, 32'hF7F70002, 32'hFDF80000, 32'hFEFE0006,
    32'hFEFE0016, 32'hFFFF0006, 32'hFFFF0016, 32'hFFFF002E, 32'hFFFF003E,
    32'hFFFF004E, 32'hFFFF005E, 32'hFFFF0066, 32'h8F800809, 32'h9F900003,
    32'hA1A00001, 32'hA3A30003, 32'hA4A40103, 32'hA5A50003, 32'hA9A80001,
    32'hABAB0003, 32'hACAC0103, 32'hB7AD0003, 32'hBABA0103, 32'hC1BC0003,
    32'hCFC80001
  };

endpackage

// ===== design/x86ild_code_if.sv =====
// ----------------------------------------------------------------------------
// x86ild_code_if
// Valid/ready channel that carries one code byte request.
// ----------------------------------------------------------------------------
interface x86ild_code_if import x86ild_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/x86ild_result_if.sv =====
// ----------------------------------------------------------------------------
// x86ild_result_if
// Valid/ready channel that carries one decoded length request.
// ----------------------------------------------------------------------------
interface x86ild_result_if import x86ild_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/x86ild_match.sv =====
// ----------------------------------------------------------------------------
// x86ild_match
// Parallel priority search of the opcode size table.
// ----------------------------------------------------------------------------
module x86ild_match import x86ild_pkg::*; #(
  parameter int TABLE_ENTRIES = 101
) (
  input  logic [7:0] opcode,
  input  logic       escaped,
  input  logic       sub_known,
  input  logic [2:0] subcode,
  output match_t     result
);

  logic [31:0] slot [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cand;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_slot
    if (g < ROM_FILL) begin : g_fill
      assign slot[g] = SIZE_ROM[g];
    end else begin : g_empty
      assign slot[g] = '0;
    end
    // Every slot compares against the key on its own.
    assign cand[g] = (slot[g] != '0) && (opcode >= slot[g][23:16]) &&
                     (opcode <= slot[g][31:24]) && (slot[g][0] == escaped) &&
                     !((slot[g][2:1] == 2'b11) && sub_known &&
                       (slot[g][6:4] != subcode));
  end

  // The lowest matching slot wins.
  always_comb begin
    logic taken;
    taken  = 1'b0;
    result = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cand[i] && !taken) begin
        taken = 1'b1;
        if ((slot[i][2:1] == 2'b11) && !sub_known) begin
          result.group_wait = 1'b1;
        end else begin
          result.found = 1'b1;
          result.entry = slot[i];
        end
      end
    end
  end

endmodule

// ===== design/x86ild_core.sv =====
// ----------------------------------------------------------------------------
// x86ild_core
// Per-instruction decode state and the one-byte decode step.
// ----------------------------------------------------------------------------
module x86ild_core import x86ild_pkg::*; #(
  parameter int TABLE_ENTRIES = 101,
  parameter int MAX_PREFIXES  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] code_byte,
  input  logic       restart,
  output step_t      step
);

  phase_t     phase, phase_next;
  logic       opsz, opsz_next;
  logic       adsz, adsz_next;
  logic       esc, esc_next;
  logic [5:0] count;
  logic [7:0] held_op, held_op_next;
  logic       branch, branch_next;
  logic [1:0] mode, mode_next;
  logic [5:0] remain, remain_next;

  // State as seen by this byte, after a restart has dropped the old one.
  phase_t     b_phase;
  logic       b_opsz, b_adsz, b_esc, b_branch;
  logic [5:0] b_count, b_remain;
  logic [7:0] b_held;
  logic [1:0] b_mode;

  logic       is_pfx, take_pfx, take_op, in_group;
  match_t     hit;
  logic [5:0] imm, disp, modrm_rem, fin_rem;
  logic       need_sib, go_finish, do_emit, emit_bad;

  function automatic logic prefix_byte(input logic [7:0] b);
    return (b == BYTE_SEG_ES) || (b == BYTE_SEG_CS) || (b == BYTE_SEG_SS) ||
           (b == BYTE_SEG_DS) || (b == BYTE_SEG_FS) || (b == BYTE_SEG_GS) ||
           (b == BYTE_OPSIZE) || (b == BYTE_ADSIZE) || (b == BYTE_WAIT) ||
           (b == BYTE_LOCK) || (b == BYTE_REPNE) || (b == BYTE_REP);
  endfunction

  always_comb begin
    b_phase  = restart ? PH_PREFIX : phase;
    b_opsz   = restart ? 1'b0 : opsz;
    b_adsz   = restart ? 1'b0 : adsz;
    b_esc    = restart ? 1'b0 : esc;
    b_branch = restart ? 1'b0 : branch;
    b_count  = restart ? '0 : count;
    b_remain = restart ? '0 : remain;
    b_held   = restart ? '0 : held_op;
    b_mode   = restart ? '0 : mode;
  end

  assign is_pfx   = prefix_byte(code_byte);
  assign take_pfx = (b_phase == PH_PREFIX) && (b_count < 6'(MAX_PREFIXES)) && is_pfx;
  assign take_op  = ((b_phase == PH_PREFIX) && !take_pfx && (code_byte != BYTE_ESCAPE)) ||
                    (b_phase == PH_OPCODE);
  assign in_group = (b_phase == PH_GROUP);

  x86ild_match #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_match (
    .opcode   (in_group ? b_held : code_byte),
    .escaped  (b_esc),
    .sub_known(in_group),
    .subcode  (code_byte[5:3]),
    .result   (hit)
  );

  // Immediate bytes of the chosen entry under the current size overrides.
  always_comb begin
    imm = 6'(hit.entry[10:8]) + 6'(hit.entry[14:12]);
    if (hit.entry[11]) imm = imm + (b_opsz ? 6'd2 : 6'd4);
    if (hit.entry[15]) imm = imm + (b_adsz ? 6'd2 : 6'd4);
  end

  // ModRM displacement and SIB detection for this byte.
  always_comb begin
    disp = '0;
    if (((code_byte[7:6] == 2'd0) && (code_byte[2:0] == (b_adsz ? 3'd6 : 3'd5))) ||
        (code_byte[7:6] == 2'd2)) begin
      disp = b_adsz ? 6'd2 : 6'd4;
    end else if (code_byte[7:6] == 2'd1) begin
      disp = 6'd1;
    end
    modrm_rem = (in_group ? imm : b_remain) + disp;
    need_sib  = (code_byte[7:6] != 2'd3) && !b_adsz && (code_byte[2:0] == 3'd4);
  end

  // Next phase, remaining byte count and the result event.
  always_comb begin
    phase_next  = b_phase;
    remain_next = b_remain;
    go_finish   = 1'b0;
    fin_rem     = b_remain;
    do_emit     = 1'b0;
    emit_bad    = 1'b0;
    unique case (b_phase) inside
      PH_PREFIX, PH_OPCODE: begin
        if (take_pfx) begin
          phase_next = PH_PREFIX;
        end else if ((b_phase == PH_PREFIX) && (code_byte == BYTE_ESCAPE)) begin
          phase_next = PH_OPCODE;
        end else if (hit.group_wait) begin
          phase_next = PH_GROUP;
        end else if (!hit.found) begin
          do_emit  = 1'b1;
          emit_bad = 1'b1;
        end else if (hit.entry[1]) begin
          phase_next  = PH_MODRM;
          remain_next = imm;
        end else begin
          go_finish = 1'b1;
          fin_rem   = imm;
        end
      end
      PH_GROUP, PH_MODRM: begin
        if (in_group && !hit.found) begin
          do_emit  = 1'b1;
          emit_bad = 1'b1;
        end else if (in_group && !hit.entry[1]) begin
          go_finish = 1'b1;
          fin_rem   = imm;
        end else if (need_sib) begin
          phase_next  = PH_SIB;
          remain_next = modrm_rem;
        end else begin
          go_finish = 1'b1;
          fin_rem   = modrm_rem;
        end
      end
      PH_SIB: begin
        go_finish = 1'b1;
        fin_rem   = ((b_mode == 2'd0) && (code_byte[2:0] == 3'd5)) ? b_remain + 6'd4
                                                                  : b_remain;
      end
      PH_TAIL: begin
        go_finish = 1'b1;
        fin_rem   = (b_remain == '0) ? '0 : b_remain - 6'd1;
      end
      default: begin
        phase_next = PH_PREFIX;
      end
    endcase
    if (go_finish) begin
      if (fin_rem == '0) begin
        do_emit = 1'b1;
      end else begin
        phase_next  = PH_TAIL;
        remain_next = fin_rem;
      end
    end
    if (do_emit) begin
      phase_next  = PH_PREFIX;
      remain_next = '0;
    end
  end

  // Per-instruction fields and the result of this step.
  always_comb begin
    opsz_next    = b_opsz | (take_pfx && (code_byte == BYTE_OPSIZE));
    adsz_next    = b_adsz | (take_pfx && (code_byte == BYTE_ADSIZE));
    esc_next     = b_esc | ((b_phase == PH_PREFIX) && !take_pfx &&
                            (code_byte == BYTE_ESCAPE));
    held_op_next = take_op ? code_byte : b_held;
    branch_next  = ((take_op || in_group) && hit.found) ? hit.entry[3] : b_branch;
    mode_next    = ((b_phase == PH_MODRM) || in_group) ? code_byte[7:6] : b_mode;

    step.emit        = do_emit;
    step.insn_length = b_count + 6'd1;
    step.is_branch   = !emit_bad && branch_next;
    step.bad_code    = emit_bad;

    if (do_emit) begin
      opsz_next    = 1'b0;
      adsz_next    = 1'b0;
      esc_next     = 1'b0;
      held_op_next = '0;
      branch_next  = 1'b0;
      mode_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_PREFIX;
      opsz    <= 1'b0;
      adsz    <= 1'b0;
      esc     <= 1'b0;
      count   <= '0;
      held_op <= '0;
      branch  <= 1'b0;
      mode    <= '0;
      remain  <= '0;
    end else if (go) begin
      phase   <= phase_next;
      opsz    <= opsz_next;
      adsz    <= adsz_next;
      esc     <= esc_next;
      count   <= do_emit ? '0 : b_count + 6'd1;
      held_op <= held_op_next;
      branch  <= branch_next;
      mode    <= mode_next;
      remain  <= remain_next;
    end
  end

endmodule

// ===== design/x86_instruction_length_decoder.sv =====
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder
// Length decoder for 32-bit x86 code fed one byte per request.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload                              | Requests
//   --------+-----------+--------------------------------------+-------------------
//   code    | in        | code_byte[7:0], restart              | one per code byte
//   result  | out       | insn_length[5:0], is_branch, bad_code | one per instruction
//
// Each code byte request is taken into an input register and decoded from
// there by the table search and state update; one byte is handled every
// cycle while the result side does not hold the decode step back.
// A result request leaves through an output register that the decode step
// of its last byte loads. When that register is full and not taken, the
// input register holds its byte and code.ready drops until it drains.
// Synchronous reset returns the decoder to the prefix phase of a new
// instruction and empties both registers.
module x86_instruction_length_decoder import x86ild_pkg::*; #(
  parameter int TABLE_ENTRIES = 101,
  parameter int MAX_PREFIXES  = 16
) (
  input logic         clk,
  input logic         rst,
  x86ild_code_if.sink   code,
  x86ild_result_if.source result
);

  // Input register: one code byte waiting for its decode step.
  logic    in_valid;
  code_t   in_data;

  // Output register: one finished result waiting to be taken.
  logic    res_valid;
  result_t res_data;

  step_t   step;
  logic    step_go;

  // The decode step runs when a byte is held and the result side can take
  // whatever it produces. Bytes that finish no instruction still need this,
  // so they also wait while the output register is full and not taken.
  assign step_go    = in_valid && (!res_valid || result.ready);
  assign code.ready = !in_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (code.ready) begin
      in_valid <= code.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (code.valid && code.ready) begin
      in_data <= code.data;
    end
  end

  x86ild_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_PREFIXES (MAX_PREFIXES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (step_go),
    .code_byte(in_data.code_byte),
    .restart  (in_data.restart),
    .step     (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || result.ready) begin
      res_valid <= step_go && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && step.emit) begin
      res_data.insn_length <= step.insn_length;
      res_data.is_branch   <= step.is_branch;
      res_data.bad_code    <= step.bad_code;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

endmodule
